/* sv/cst_pkg.sv */
package cst_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MUL_NUM,
    S_MUL_DEN,
    S_DIV_INIT,
    S_DIV,
    S_MUL_SLOPE,
    S_ADD_SAT,
    S_MUL_GL,
    S_MUL_GH,
    S_COMB,
    S_CLAMP,
    S_FINISH
  } state_t;

  // Search phase of a probe run
  typedef enum logic [1:0] {
    PH_SEEK_CONTACT,
    PH_SEEK_PASS,
    PH_DONE
  } phase_t;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_CONTACT = 2'd1;
  localparam logic [1:0] ST_NO_PASS    = 2'd2;
  localparam logic [1:0] ST_ZERO_SPAN  = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_CONTACT_LEVEL = 3'd0;
  localparam logic [2:0] REG_PASS_LEVEL    = 3'd1;
  localparam logic [2:0] REG_PROBE_SPEED   = 3'd2;
  localparam logic [2:0] REG_SLOPE_COEF    = 3'd3;
  localparam logic [2:0] REG_OFFSET_COEF   = 3'd4;
  localparam logic [2:0] REG_STEP_GAIN     = 3'd5;
  localparam logic [2:0] REG_MIN_TIME      = 3'd6;
  localparam logic [2:0] REG_MAX_TIME      = 3'd7;

  // Register reset values
  localparam logic [23:0] RST_CONTACT_LEVEL = 24'd1024;
  localparam logic [23:0] RST_PASS_LEVEL    = 24'd3072;
  localparam logic [19:0] RST_PROBE_SPEED   = 20'd10000;
  localparam logic [23:0] RST_SLOPE_COEF    = 24'hFE7000; // -102400
  localparam logic [23:0] RST_OFFSET_COEF   = 24'd900000;
  localparam logic [15:0] RST_STEP_GAIN     = 16'd256;
  localparam logic [23:0] RST_MIN_TIME      = 24'd300000;
  localparam logic [23:0] RST_MAX_TIME      = 24'd700000;

  // 10^12 = 5^12 * 2^12; 1024 in the denominator is a shift by 10
  localparam logic [32:0] FIVE_POW12 = 33'd244140625;

  // Saturation limit of the linear map, Q8 us
  localparam logic signed [65:0] LIM40 = 66'sd1 <<< 40;

endpackage

/* sv/contact_stiffness_step_time.sv */
// Channel  | Ports                                                  | Direction
// ---------+--------------------------------------------------------+----------
// input    | in_valid/in_ready, in_force_magnitude, in_sample_time, | in
//          | in_last_sample                                         |
// result   | out_valid/out_ready, out_move_time, out_stiffness,     | out
//          | out_status                                             |
// config   | cfg_we, cfg_index, cfg_data                            | in
//
// A sample without the last mark is taken while the block stays idle; such samples can go back to back.
// A last sample with a valid span keeps in_ready low through evaluate, numerator and
// denominator multiplies, divide setup, a 64-step restoring divide (one subtract per
// cycle), slope multiply, offset add with saturation, two gain half-multiplies, combine,
// clamp and hand-off; the multiplies use the shared 33x33 multiplier. A last sample with
// no contact, no pass or zero span keeps it low only through evaluate and hand-off.
// Reset is synchronous, active low; it restores the register defaults and clears the search.
// The result sits in an output register, so new samples are taken while it waits; the
// hand-off state stalls only while that register still holds an unaccepted word.
module contact_stiffness_step_time (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_force_magnitude,
  input  logic [31:0] in_sample_time,
  input  logic        in_last_sample,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_move_time,
  output logic [31:0] out_stiffness,
  output logic [1:0]  out_status,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // configuration registers
  logic [23:0] contact_level_r, pass_level_r;
  logic [19:0] probe_speed_r;
  logic [23:0] slope_coef_r, offset_coef_r;
  logic [15:0] step_gain_r;
  logic [23:0] min_time_r, max_time_r;

  // search state
  cst_pkg::phase_t phase_r;
  logic [23:0] contact_force_r, pass_force_r;
  logic [31:0] contact_time_r, pass_time_r;

  // sequencer and datapath
  cst_pkg::state_t state_r, state_nxt;
  logic [23:0] df_r;
  logic [31:0] dt_r;
  logic [1:0]  status_r;
  logic [63:0] quo_r;
  logic [61:0] rem_r;
  logic [61:0] den_r;
  logic [5:0]  cnt_r;
  logic signed [65:0] prod_r;
  logic signed [41:0] v_r;
  logic [36:0] plo_r;
  logic signed [57:0] full_r;
  logic [31:0] stiff_r;
  logic [23:0] mt_r;

  // output register
  logic        out_valid_r;
  logic [23:0] out_move_time_r;
  logic [31:0] out_stiffness_r;
  logic [1:0]  out_status_r;

  logic accept;
  logic finish_go;

  assign in_ready      = (state_r == cst_pkg::S_IDLE);
  assign accept        = in_valid && in_ready;
  assign finish_go     = (state_r == cst_pkg::S_FINISH) && (!out_valid_r || out_ready);
  assign out_valid     = out_valid_r;
  assign out_move_time = out_move_time_r;
  assign out_stiffness = out_stiffness_r;
  assign out_status    = out_status_r;

  // span evaluation on held values
  logic [23:0] df_w;
  logic [31:0] dt_w;
  logic [1:0]  status_w;
  always_comb begin
    df_w = (pass_force_r >= contact_force_r) ? pass_force_r - contact_force_r
                                             : contact_force_r - pass_force_r;
    dt_w = (pass_time_r >= contact_time_r) ? pass_time_r - contact_time_r
                                           : contact_time_r - pass_time_r;
    if (phase_r == cst_pkg::PH_SEEK_CONTACT) begin
      status_w = cst_pkg::ST_NO_CONTACT;
    end else if (phase_r != cst_pkg::PH_DONE) begin
      status_w = cst_pkg::ST_NO_PASS;
    end else if (dt_w == 32'd0 || probe_speed_r == 20'd0) begin
      status_w = cst_pkg::ST_ZERO_SPAN;
    end else begin
      status_w = cst_pkg::ST_OK;
    end
  end

  // shared multiplier operand select
  logic signed [32:0] mul_a, mul_b;
  logic [31:0] k_sat;
  always_comb begin
    k_sat = (quo_r[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo_r[31:0];
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      cst_pkg::S_MUL_NUM: begin
        mul_a = {9'd0, df_r};
        mul_b = cst_pkg::FIVE_POW12;
      end
      cst_pkg::S_MUL_DEN: begin
        mul_a = {1'b0, dt_r};
        mul_b = {13'd0, probe_speed_r};
      end
      cst_pkg::S_MUL_SLOPE: begin
        mul_a = {{9{slope_coef_r[23]}}, slope_coef_r};
        mul_b = {1'b0, k_sat};
      end
      cst_pkg::S_MUL_GL: begin
        mul_a = {12'd0, v_r[20:0]};
        mul_b = {17'd0, step_gain_r};
      end
      cst_pkg::S_MUL_GH: begin
        mul_a = {{12{v_r[41]}}, v_r[41:21]};
        mul_b = {17'd0, step_gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divide step: shift in next dividend bit, trial subtract
  logic [62:0] shifted_w;
  logic [63:0] diff_w;
  always_comb begin
    shifted_w = {rem_r, quo_r[63]};
    diff_w    = {1'b0, shifted_w} - {2'b0, den_r};
  end

  // offset add and saturation of the linear map
  logic signed [65:0] off_ext, sum_w;
  always_comb begin
    off_ext = {{34{offset_coef_r[23]}}, offset_coef_r, 8'd0};
    sum_w   = prod_r + off_ext;
  end

  // clamp against min and max time in Q16
  logic signed [57:0] lo_w, hi_w, clamp_w;
  always_comb begin
    lo_w = {18'd0, min_time_r, 16'd0};
    hi_w = {18'd0, max_time_r, 16'd0};
    clamp_w = (full_r < lo_w) ? lo_w : full_r;
    if (clamp_w > hi_w) clamp_w = hi_w;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cst_pkg::S_IDLE:      if (accept && in_last_sample) state_nxt = cst_pkg::S_EVAL;
      cst_pkg::S_EVAL:      state_nxt = (status_w == cst_pkg::ST_OK) ? cst_pkg::S_MUL_NUM
                                                                     : cst_pkg::S_FINISH;
      cst_pkg::S_MUL_NUM:   state_nxt = cst_pkg::S_MUL_DEN;
      cst_pkg::S_MUL_DEN:   state_nxt = cst_pkg::S_DIV_INIT;
      cst_pkg::S_DIV_INIT:  state_nxt = cst_pkg::S_DIV;
      cst_pkg::S_DIV:       if (cnt_r == 6'd63) state_nxt = cst_pkg::S_MUL_SLOPE;
      cst_pkg::S_MUL_SLOPE: state_nxt = cst_pkg::S_ADD_SAT;
      cst_pkg::S_ADD_SAT:   state_nxt = cst_pkg::S_MUL_GL;
      cst_pkg::S_MUL_GL:    state_nxt = cst_pkg::S_MUL_GH;
      cst_pkg::S_MUL_GH:    state_nxt = cst_pkg::S_COMB;
      cst_pkg::S_COMB:      state_nxt = cst_pkg::S_CLAMP;
      cst_pkg::S_CLAMP:     state_nxt = cst_pkg::S_FINISH;
      cst_pkg::S_FINISH:    if (finish_go) state_nxt = cst_pkg::S_IDLE;
      default:              state_nxt = cst_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contact_level_r <= cst_pkg::RST_CONTACT_LEVEL;
      pass_level_r    <= cst_pkg::RST_PASS_LEVEL;
      probe_speed_r   <= cst_pkg::RST_PROBE_SPEED;
      slope_coef_r    <= cst_pkg::RST_SLOPE_COEF;
      offset_coef_r   <= cst_pkg::RST_OFFSET_COEF;
      step_gain_r     <= cst_pkg::RST_STEP_GAIN;
      min_time_r      <= cst_pkg::RST_MIN_TIME;
      max_time_r      <= cst_pkg::RST_MAX_TIME;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cst_pkg::REG_CONTACT_LEVEL: contact_level_r <= cfg_data;
        cst_pkg::REG_PASS_LEVEL:    pass_level_r    <= cfg_data;
        cst_pkg::REG_PROBE_SPEED:   probe_speed_r   <= cfg_data[19:0];
        cst_pkg::REG_SLOPE_COEF:    slope_coef_r    <= cfg_data;
        cst_pkg::REG_OFFSET_COEF:   offset_coef_r   <= cfg_data;
        cst_pkg::REG_STEP_GAIN:     step_gain_r     <= cfg_data[15:0];
        cst_pkg::REG_MIN_TIME:      min_time_r      <= cfg_data;
        cst_pkg::REG_MAX_TIME:      max_time_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // contact / pass search, cleared once the run is evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= cst_pkg::PH_SEEK_CONTACT;
      contact_force_r <= '0;
      contact_time_r  <= '0;
      pass_force_r    <= '0;
      pass_time_r     <= '0;
    end else if (state_r == cst_pkg::S_EVAL) begin
      phase_r         <= cst_pkg::PH_SEEK_CONTACT;
      contact_force_r <= '0;
      contact_time_r  <= '0;
      pass_force_r    <= '0;
      pass_time_r     <= '0;
    end else if (accept) begin
      case (phase_r)
        cst_pkg::PH_SEEK_CONTACT: begin
          if (in_force_magnitude > contact_level_r) begin
            contact_force_r <= in_force_magnitude;
            contact_time_r  <= in_sample_time;
            phase_r         <= cst_pkg::PH_SEEK_PASS;
          end
        end
        cst_pkg::PH_SEEK_PASS: begin
          if (in_force_magnitude > pass_level_r) begin
            pass_force_r <= in_force_magnitude;
            pass_time_r  <= in_sample_time;
            phase_r      <= cst_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (state_r)
        cst_pkg::S_EVAL: begin
          df_r     <= df_w;
          dt_r     <= dt_w;
          status_r <= status_w;
          stiff_r  <= '0;
          mt_r     <= '0;
        end
        cst_pkg::S_MUL_NUM: begin
          prod_r <= mul_a * mul_b;
        end
        cst_pkg::S_MUL_DEN: begin
          quo_r  <= {prod_r[51:0], 12'd0};
          prod_r <= mul_a * mul_b;
        end
        cst_pkg::S_DIV_INIT: begin
          den_r <= {prod_r[51:0], 10'd0};
          rem_r <= '0;
          cnt_r <= '0;
        end
        cst_pkg::S_DIV: begin
          if (!diff_w[63]) begin
            rem_r <= diff_w[61:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= shifted_w[61:0];
            quo_r <= {quo_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
        end
        cst_pkg::S_MUL_SLOPE: begin
          stiff_r <= k_sat;
          prod_r  <= mul_a * mul_b;
        end
        cst_pkg::S_ADD_SAT: begin
          if (sum_w > cst_pkg::LIM40) begin
            v_r <= cst_pkg::LIM40[41:0];
          end else if (sum_w < -cst_pkg::LIM40) begin
            v_r <= 42'(-cst_pkg::LIM40);
          end else begin
            v_r <= sum_w[41:0];
          end
        end
        cst_pkg::S_MUL_GL: begin
          prod_r <= mul_a * mul_b;
        end
        cst_pkg::S_MUL_GH: begin
          plo_r  <= prod_r[36:0];
          prod_r <= mul_a * mul_b;
        end
        cst_pkg::S_COMB: begin
          full_r <= {prod_r[36:0], 21'd0} + {21'd0, plo_r};
        end
        cst_pkg::S_CLAMP: begin
          mt_r <= clamp_w[39:16];
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_go) begin
      out_valid_r     <= 1'b1;
      out_move_time_r <= mt_r;
      out_stiffness_r <= stiff_r;
      out_status_r    <= status_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
